### rtl/mrmt_pkg.sv
// ----------------------------------------------------------------------------
// mrmt_pkg: shared constants for the multipath route merge table
// Command and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mrmt_pkg;

  // parameter defaults
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int PORT_BITS_DEF   = 8;
  localparam int MAX_IFACES_DEF  = 4;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int COST_W    = 16;
  localparam int STATUS_W  = 4;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NIF_W     = 3;
  localparam int NUM_IFACE_REGS = 4;

  // commands
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_IFACES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IFACE_D    = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NEW        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_PRI_JOIN   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BACKUP_SET = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BACKUP_JOIN= 4'd3;
  localparam logic [STATUS_W-1:0] ST_PRI_REPL   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_LOCAL_SKIP = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FULL       = 4'd7;
  localparam logic [STATUS_W-1:0] ST_ENTRY      = 4'd8;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd9;
  localparam logic [STATUS_W-1:0] ST_CLEARED    = 4'd10;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

### rtl/mrmt_cell.sv
// ----------------------------------------------------------------------------
// mrmt_cell: one route table slot in the rotating ring
// Holds one packed entry and takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mrmt_cell #(
  parameter int ENTRY_W = 128
) (
  input  wire logic               clk,
  input  wire logic               shift_en,
  input  wire logic [ENTRY_W-1:0] entry_in,
  output logic      [ENTRY_W-1:0] entry_out
);

  logic [ENTRY_W-1:0] entry_r;

  // payload register, moves one place along the ring per shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= entry_in;
    end
  end

  assign entry_out = entry_r;

endmodule

`default_nettype wire

### rtl/multipath_route_merge_table.sv
// ----------------------------------------------------------------------------
// multipath_route_merge_table: ECMP route table with backup paths
// Ring of slot cells rotated by a small sequencer that merges, flushes and
// clears routes.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_DEPTH cells that rotates one place per cycle
// in the scan state, so every slot passes the merge logic once. An offer runs
// a full rotation in S_SCAN and then S_DONE, which registers its result word
// onto the out_ ports; the next command is taken in the cycle that word is
// out. A flush gives one word per stored entry, newest first, during a full
// rotation and takes the next command in the cycle its last word is out;
// clear and an empty flush answer in the next cycle. busy is high while a
// command runs. Each result word is on the out_ ports for one cycle with
// out_valid high and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module multipath_route_merge_table #(
  parameter int TABLE_DEPTH = mrmt_pkg::TABLE_DEPTH_DEF,
  parameter int PORT_BITS   = mrmt_pkg::PORT_BITS_DEF,
  parameter int MAX_IFACES  = mrmt_pkg::MAX_IFACES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mrmt_pkg::CMD_W-1:0]     in_command,
  input  wire logic [mrmt_pkg::ADDR_W-1:0]    in_subnet,
  input  wire logic [mrmt_pkg::ADDR_W-1:0]    in_netmask,
  input  wire logic [mrmt_pkg::COST_W-1:0]    in_path_cost,
  input  wire logic [PORT_BITS-1:0]           in_port_bits,
  // result channel
  output logic                                out_valid,
  output logic [mrmt_pkg::STATUS_W-1:0]       out_status,
  output logic [mrmt_pkg::ADDR_W-1:0]         out_route_dest,
  output logic [mrmt_pkg::ADDR_W-1:0]         out_route_mask,
  output logic [PORT_BITS-1:0]                out_primary_ports,
  output logic [PORT_BITS-1:0]                out_backup_ports,
  output logic                                out_last,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mrmt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mrmt_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int AW = mrmt_pkg::ADDR_W;
  localparam int CWD = mrmt_pkg::COST_W;
  localparam int ENTRY_W = 2 * AW + 2 * PORT_BITS + 2 * CWD;
  localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TW-1:0] LAST_T = TW'(TABLE_DEPTH - 1);
  localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

  // entry layout: {dest, mask, primary, backup, primary cost, backup cost}
  localparam int BC_LO = 0;
  localparam int PC_LO = BC_LO + CWD;
  localparam int BK_LO = PC_LO + CWD;
  localparam int PR_LO = BK_LO + PORT_BITS;
  localparam int MK_LO = PR_LO + PORT_BITS;
  localparam int DS_LO = MK_LO + AW;

  // configuration registers
  logic [mrmt_pkg::NIF_W-1:0] num_ifaces_r;
  logic [AW-1:0]              iface_ip_r [mrmt_pkg::NUM_IFACE_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ifaces_r <= '0;
      for (int j = 0; j < mrmt_pkg::NUM_IFACE_REGS; j++) begin
        iface_ip_r[j] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        mrmt_pkg::REG_NUM_IFACES: num_ifaces_r  <= cfg_data[mrmt_pkg::NIF_W-1:0];
        mrmt_pkg::REG_IFACE_A:    iface_ip_r[0] <= cfg_data;
        mrmt_pkg::REG_IFACE_B:    iface_ip_r[1] <= cfg_data;
        mrmt_pkg::REG_IFACE_C:    iface_ip_r[2] <= cfg_data;
        mrmt_pkg::REG_IFACE_D:    iface_ip_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // local interface check on the incoming candidate
  logic local_hit;
  always_comb begin
    local_hit = 1'b0;
    for (int j = 0; j < mrmt_pkg::NUM_IFACE_REGS; j++) begin
      if (j < MAX_IFACES && 32'(j) < 32'(num_ifaces_r) &&
          (iface_ip_r[j] & in_netmask) == in_subnet) begin
        local_hit = 1'b1;
      end
    end
  end

  // ring of cells
  logic [ENTRY_W-1:0] ring_q [TABLE_DEPTH];
  logic [ENTRY_W-1:0] wrap_entry;
  logic               shift_en;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    mrmt_cell #(.ENTRY_W(ENTRY_W)) u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .entry_in  ((g == 0) ? wrap_entry : ring_q[(g == 0) ? 0 : g - 1]),
      .entry_out (ring_q[g])
    );
  end

  // control and held command
  mrmt_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]    t_r, t_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             found_r, found_nxt;
  logic             local_r, local_nxt;
  logic [mrmt_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [AW-1:0]    sub_r, sub_nxt, msk_r, msk_nxt;
  logic [CWD-1:0]   cost_r, cost_nxt;
  logic [PORT_BITS-1:0] port_r, port_nxt;

  // held merge result
  logic [mrmt_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [AW-1:0]        res_dest_r, res_dest_nxt, res_mask_r, res_mask_nxt;
  logic [PORT_BITS-1:0] res_pri_r, res_pri_nxt, res_bk_r, res_bk_nxt;

  // output word registers
  logic                          ov_r, ov_nxt, ol_r, ol_nxt;
  logic [mrmt_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [AW-1:0]                 od_r, od_nxt, om_r, om_nxt;
  logic [PORT_BITS-1:0]          op_r, op_nxt, ob_r, ob_nxt;

  // head of the ring
  logic [AW-1:0]        h_dest, h_mask;
  logic [PORT_BITS-1:0] h_pri, h_bk;
  logic [CWD-1:0]       h_pc, h_bc;
  logic [TW-1:0]        slot;
  logic                 in_table;

  assign h_dest = ring_q[TABLE_DEPTH-1][DS_LO +: AW];
  assign h_mask = ring_q[TABLE_DEPTH-1][MK_LO +: AW];
  assign h_pri  = ring_q[TABLE_DEPTH-1][PR_LO +: PORT_BITS];
  assign h_bk   = ring_q[TABLE_DEPTH-1][BK_LO +: PORT_BITS];
  assign h_pc   = ring_q[TABLE_DEPTH-1][PC_LO +: CWD];
  assign h_bc   = ring_q[TABLE_DEPTH-1][BC_LO +: CWD];
  assign slot   = LAST_T - t_r;
  assign in_table = NW'(slot) < count_r;
  assign shift_en = (state_r == mrmt_pkg::S_SCAN);
  assign busy = (state_r != mrmt_pkg::S_IDLE);

  // merge of a candidate into the matching entry
  logic [mrmt_pkg::STATUS_W-1:0] m_st;
  logic [PORT_BITS-1:0] m_pri, m_bk;
  logic [CWD-1:0]       m_pc, m_bc;
  always_comb begin
    m_st = mrmt_pkg::ST_LOCAL_SKIP;
    m_pri = h_pri;
    m_bk = h_bk;
    m_pc = h_pc;
    m_bc = h_bc;
    if (local_r) begin
      m_st = mrmt_pkg::ST_LOCAL_SKIP;
    end else if (cost_r == h_pc) begin
      m_pri = h_pri | port_r;
      m_st = mrmt_pkg::ST_PRI_JOIN;
    end else if (cost_r > h_pc) begin
      if (h_bk == '0 || cost_r < h_bc) begin
        m_bk = port_r;
        m_bc = cost_r;
        m_st = mrmt_pkg::ST_BACKUP_SET;
      end else if (cost_r == h_bc) begin
        m_bk = h_bk | port_r;
        m_st = mrmt_pkg::ST_BACKUP_JOIN;
      end else begin
        m_st = mrmt_pkg::ST_UNCHANGED;
      end
    end else begin
      m_pri = port_r;
      m_pc = cost_r;
      if (h_bk == '0 || h_pc < h_bc) begin
        m_bk = h_pri;
        m_bc = h_pc;
      end
      m_st = mrmt_pkg::ST_PRI_REPL;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    t_nxt = t_r;
    count_nxt = count_r;
    found_nxt = found_r;
    local_nxt = local_r;
    cmd_nxt = cmd_r;
    sub_nxt = sub_r;
    msk_nxt = msk_r;
    cost_nxt = cost_r;
    port_nxt = port_r;
    res_st_nxt = res_st_r;
    res_dest_nxt = res_dest_r;
    res_mask_nxt = res_mask_r;
    res_pri_nxt = res_pri_r;
    res_bk_nxt = res_bk_r;
    ov_nxt = 1'b0;
    ol_nxt = 1'b0;
    ost_nxt = ost_r;
    od_nxt = od_r;
    om_nxt = om_r;
    op_nxt = op_r;
    ob_nxt = ob_r;
    wrap_entry = ring_q[TABLE_DEPTH-1];
    case (state_r)
      mrmt_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          sub_nxt = in_subnet;
          msk_nxt = in_netmask;
          cost_nxt = in_path_cost;
          port_nxt = in_port_bits;
          local_nxt = local_hit;
          found_nxt = 1'b0;
          t_nxt = '0;
          case (in_command)
            mrmt_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              ov_nxt = 1'b1;
              ol_nxt = 1'b1;
              ost_nxt = mrmt_pkg::ST_CLEARED;
              od_nxt = '0;
              om_nxt = '0;
              op_nxt = '0;
              ob_nxt = '0;
            end
            mrmt_pkg::CMD_FLUSH: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1;
                ol_nxt = 1'b1;
                ost_nxt = mrmt_pkg::ST_EMPTY;
                od_nxt = '0;
                om_nxt = '0;
                op_nxt = '0;
                ob_nxt = '0;
              end else begin
                state_nxt = mrmt_pkg::S_SCAN;
              end
            end
            mrmt_pkg::CMD_OFFER: state_nxt = mrmt_pkg::S_SCAN;
            default: ;
          endcase
        end
      end
      mrmt_pkg::S_SCAN: begin
        if (cmd_r == mrmt_pkg::CMD_FLUSH) begin
          if (in_table) begin
            ov_nxt = 1'b1;
            ol_nxt = (slot == '0);
            ost_nxt = mrmt_pkg::ST_ENTRY;
            od_nxt = h_dest;
            om_nxt = h_mask;
            op_nxt = h_pri;
            ob_nxt = h_bk;
          end
        end else if (in_table && h_dest == sub_r) begin
          found_nxt = 1'b1;
          wrap_entry = {h_dest, h_mask, m_pri, m_bk, m_pc, m_bc};
          res_st_nxt = m_st;
          res_dest_nxt = h_dest;
          res_mask_nxt = h_mask;
          res_pri_nxt = m_pri;
          res_bk_nxt = m_bk;
        end else if (NW'(slot) == count_r) begin
          // stage the candidate in the first free slot
          wrap_entry = {sub_r, msk_r, port_r, {PORT_BITS{1'b0}}, cost_r, {CWD{1'b0}}};
        end
        t_nxt = t_r + 1'b1;
        if (t_r == LAST_T) begin
          t_nxt = '0;
          state_nxt = (cmd_r == mrmt_pkg::CMD_FLUSH) ? mrmt_pkg::S_IDLE
                                                     : mrmt_pkg::S_DONE;
        end
      end
      mrmt_pkg::S_DONE: begin
        ov_nxt = 1'b1;
        ol_nxt = 1'b1;
        if (found_r) begin
          ost_nxt = res_st_r;
          od_nxt = res_dest_r;
          om_nxt = res_mask_r;
          op_nxt = res_pri_r;
          ob_nxt = res_bk_r;
        end else if (count_r >= DEPTH_N) begin
          ost_nxt = mrmt_pkg::ST_FULL;
          od_nxt = sub_r;
          om_nxt = msk_r;
          op_nxt = '0;
          ob_nxt = '0;
        end else begin
          ost_nxt = mrmt_pkg::ST_NEW;
          od_nxt = sub_r;
          om_nxt = msk_r;
          op_nxt = port_r;
          ob_nxt = '0;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = mrmt_pkg::S_IDLE;
      end
      default: state_nxt = mrmt_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrmt_pkg::S_IDLE;
      t_r <= '0;
      count_r <= '0;
      found_r <= 1'b0;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t_r <= t_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      ov_r <= ov_nxt;
      ol_r <= ol_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    local_r <= local_nxt;
    cmd_r <= cmd_nxt;
    sub_r <= sub_nxt;
    msk_r <= msk_nxt;
    cost_r <= cost_nxt;
    port_r <= port_nxt;
    res_st_r <= res_st_nxt;
    res_dest_r <= res_dest_nxt;
    res_mask_r <= res_mask_nxt;
    res_pri_r <= res_pri_nxt;
    res_bk_r <= res_bk_nxt;
    ost_r <= ost_nxt;
    od_r <= od_nxt;
    om_r <= om_nxt;
    op_r <= op_nxt;
    ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_last = ol_r;
  assign out_status = ost_r;
  assign out_route_dest = od_r;
  assign out_route_mask = om_r;
  assign out_primary_ports = op_r;
  assign out_backup_ports = ob_r;

endmodule

`default_nettype wire

### tb/sv/tb_multipath_route_merge_table.sv
// ----------------------------------------------------------------------------
// tb_multipath_route_merge_table: self-checking bench for the route merge table
// Drives offers, flushes and clears with random gaps, predicts every result
// word with a behavioral route table and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multipath_route_merge_table;
  import mrmt_pkg::*;

  localparam int DEPTH = 32;
  localparam int PB    = 8;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] subnet;
    logic [ADDR_W-1:0] netmask;
    logic [COST_W-1:0] cost;
    logic [PB-1:0]     ports;
  } route_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   dest;
    logic [ADDR_W-1:0]   mask;
    logic [PB-1:0]       pri;
    logic [PB-1:0]       bak;
    logic                last;
  } route_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0]  in_command = '0;
  logic [ADDR_W-1:0] in_subnet = '0;
  logic [ADDR_W-1:0] in_netmask = '0;
  logic [COST_W-1:0] in_path_cost = '0;
  logic [PB-1:0]     in_port_bits = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_route_dest;
  logic [ADDR_W-1:0]   out_route_mask;
  logic [PB-1:0]       out_primary_ports;
  logic [PB-1:0]       out_backup_ports;
  logic                out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  multipath_route_merge_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_subnet(in_subnet), .in_netmask(in_netmask),
    .in_path_cost(in_path_cost), .in_port_bits(in_port_bits),
    .out_valid(out_valid), .out_status(out_status),
    .out_route_dest(out_route_dest), .out_route_mask(out_route_mask),
    .out_primary_ports(out_primary_ports), .out_backup_ports(out_backup_ports),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow route table
  logic [2:0]        sh_nif;
  logic [ADDR_W-1:0] sh_ifip [4];
  logic [ADDR_W-1:0] rt_dest [DEPTH];
  logic [ADDR_W-1:0] rt_mask [DEPTH];
  logic [PB-1:0]     rt_pri [DEPTH];
  logic [PB-1:0]     rt_bak [DEPTH];
  logic [COST_W-1:0] rt_pcost [DEPTH];
  logic [COST_W-1:0] rt_bcost [DEPTH];
  int                rt_count;

  route_cmd_t  pending_cmds[$];
  route_word_t expected_words[$];
  int errors = 0;
  int n_words = 0;
  int n_cmds = 0;
  bit quiet_mode = 1'b0;   // no gaps while set
  bit hold_sender = 1'b0;

  function automatic bit subnet_is_local(logic [ADDR_W-1:0] sub, logic [ADDR_W-1:0] msk);
    int n;
    n = (sh_nif < 4) ? int'(sh_nif) : 4;
    for (int j = 0; j < n; j++)
      if ((sh_ifip[j] & msk) == sub) return 1'b1;
    return 1'b0;
  endfunction

  function automatic route_word_t mk_word(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] d,
                                          logic [ADDR_W-1:0] m, logic [PB-1:0] p,
                                          logic [PB-1:0] b, logic l);
    route_word_t w;
    w.status = st; w.dest = d; w.mask = m; w.pri = p; w.bak = b; w.last = l;
    return w;
  endfunction

  // update the shadow table and queue the words a command produces
  task automatic merge_route(route_cmd_t c);
    int i;
    logic [STATUS_W-1:0] st;
    logic [PB-1:0] old_p;
    logic [COST_W-1:0] old_c;
    if (c.cmd == CMD_CLEAR) begin
      rt_count = 0;
      expected_words.push_back(mk_word(ST_CLEARED, '0, '0, '0, '0, 1'b1));
      return;
    end
    if (c.cmd == CMD_FLUSH) begin
      if (rt_count == 0) expected_words.push_back(mk_word(ST_EMPTY, '0, '0, '0, '0, 1'b1));
      for (int k = rt_count - 1; k >= 0; k--)
        expected_words.push_back(mk_word(ST_ENTRY, rt_dest[k], rt_mask[k], rt_pri[k],
                                         rt_bak[k], k == 0));
      return;
    end
    if (c.cmd != CMD_OFFER) return;
    for (i = 0; i < rt_count; i++)
      if (rt_dest[i] == c.subnet) break;
    if (i >= rt_count) begin
      if (rt_count >= DEPTH) begin
        expected_words.push_back(mk_word(ST_FULL, c.subnet, c.netmask, '0, '0, 1'b1));
        return;
      end
      i = rt_count;
      rt_dest[i] = c.subnet; rt_mask[i] = c.netmask;
      rt_pri[i] = c.ports; rt_pcost[i] = c.cost;
      rt_bak[i] = '0; rt_bcost[i] = '0;
      rt_count++;
      st = ST_NEW;
    end else if (subnet_is_local(c.subnet, c.netmask)) begin
      st = ST_LOCAL_SKIP;
    end else if (c.cost == rt_pcost[i]) begin
      rt_pri[i] |= c.ports;
      st = ST_PRI_JOIN;
    end else if (c.cost > rt_pcost[i]) begin
      if (rt_bak[i] == 0 || c.cost < rt_bcost[i]) begin
        rt_bak[i] = c.ports; rt_bcost[i] = c.cost;
        st = ST_BACKUP_SET;
      end else if (c.cost == rt_bcost[i]) begin
        rt_bak[i] |= c.ports;
        st = ST_BACKUP_JOIN;
      end else begin
        st = ST_UNCHANGED;
      end
    end else begin
      old_p = rt_pri[i]; old_c = rt_pcost[i];
      rt_pri[i] = c.ports; rt_pcost[i] = c.cost;
      if (rt_bak[i] == 0 || old_c < rt_bcost[i]) begin
        rt_bak[i] = old_p; rt_bcost[i] = old_c;
      end
      st = ST_PRI_REPL;
    end
    expected_words.push_back(mk_word(st, rt_dest[i], rt_mask[i], rt_pri[i], rt_bak[i], 1'b1));
  endtask

  // driver: one command per accepted start, random gaps
  always @(posedge clk) begin
    route_cmd_t c;
    if (rst_n) begin
      if (start && !busy) begin
        merge_route(pending_cmds.pop_front());
        n_cmds++;
      end
      if ((start && !busy) || !start) begin
        if (pending_cmds.size() != 0 && !hold_sender &&
            (quiet_mode || $urandom_range(99) >= 38)) begin
          c = pending_cmds[0];
          start <= 1'b1;
          in_command <= c.cmd; in_subnet <= c.subnet; in_netmask <= c.netmask;
          in_path_cost <= c.cost; in_port_bits <= c.ports;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    route_word_t e;
    if (rst_n && out_valid) begin
      n_words++;
      if (expected_words.size() == 0) begin
        $error("unexpected result word, status %0d", out_status);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_route_dest !== e.dest) begin
          $error("route_dest exp %h got %h", e.dest, out_route_dest); errors++;
        end
        if (out_route_mask !== e.mask) begin
          $error("route_mask exp %h got %h", e.mask, out_route_mask); errors++;
        end
        if (out_primary_ports !== e.pri) begin
          $error("primary_ports exp %h got %h", e.pri, out_primary_ports); errors++;
        end
        if (out_backup_ports !== e.bak) begin
          $error("backup_ports exp %h got %h", e.bak, out_backup_ports); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  function automatic route_cmd_t mk_cmd(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] s,
                                        logic [ADDR_W-1:0] m, logic [COST_W-1:0] k,
                                        logic [PB-1:0] p);
    route_cmd_t c;
    c.cmd = cmd; c.subnet = s; c.netmask = m; c.cost = k; c.ports = p;
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_NUM_IFACES) sh_nif = val[2:0];
    else sh_ifip[idx - 1] = val;
  endtask

  // wait until the block is idle with nothing outstanding
  task automatic drain();
    while (pending_cmds.size() != 0 || expected_words.size() != 0 || busy || start)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random phase: a small pool of subnets so merges hit known entries
  task automatic random_phase(int count, logic [ADDR_W-1:0] pool[8]);
    int r;
    logic [ADDR_W-1:0] s;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      s = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(7)];
      if (r < 4)
        pending_cmds.push_back(mk_cmd(CMD_FLUSH, $urandom, $urandom,
                                      16'($urandom), 8'($urandom)));
      else if (r < 6)
        pending_cmds.push_back(mk_cmd(CMD_CLEAR, $urandom, $urandom,
                                      16'($urandom), 8'($urandom)));
      else if (r < 8)
        pending_cmds.push_back(mk_cmd(2'd3, $urandom, $urandom,
                                      16'($urandom), 8'($urandom)));
      else pending_cmds.push_back(mk_cmd(CMD_OFFER, s,
             ($urandom_range(3) == 0) ? $urandom : 32'hFFFF_FF00,
             ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
             ($urandom_range(3) == 0) ? 8'($urandom) : (8'd1 << $urandom_range(7))));
    end
    pending_cmds.push_back(mk_cmd(CMD_FLUSH, '0, '0, '0, '0));
  endtask

  initial begin
    logic [ADDR_W-1:0] pool[8];
    for (int k = 0; k < 4; k++) sh_ifip[k] = '0;
    sh_nif = '0;
    rt_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: local interfaces, every status, extremes
    write_reg(REG_NUM_IFACES, 32'd1);
    write_reg(REG_IFACE_A, 32'h0A00_0001);
    write_reg(REG_IFACE_B, 32'hFFFF_FFFF);
    write_reg(REG_IFACE_C, 32'h0000_0000);
    write_reg(REG_IFACE_D, 32'hC0A8_0105);
    pending_cmds.push_back(mk_cmd(CMD_FLUSH, '0, '0, '0, '0));                 // empty
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'h0A00_0000, 32'hFF00_0000, 16'd5, 8'h01)); // local new
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'h0A00_0000, 32'hFF00_0000, 16'd5, 8'h02)); // skip
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'hFFFF_FF00, 16'd10, 8'h01)); // new
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'hFFFF_FF00, 16'd10, 8'h04)); // pri join
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'h0, 16'd20, 8'h08));  // backup set
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'h0, 16'd20, 8'h10));  // backup join
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'h0, 16'd30, 8'h20));  // unchanged
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'h0, 16'd15, 8'h40));  // backup lower
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hC0A8_0100, 32'h0, 16'd0, 8'h80));   // replace
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFE, 8'h00));
    pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'h0, 32'h0, 16'd0, 8'h00));
    pending_cmds.push_back(mk_cmd(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    pending_cmds.push_back(mk_cmd(CMD_FLUSH, '0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(CMD_CLEAR, '0, '0, '0, '0));
    // fill past capacity
    for (int k = 0; k < 34; k++)
      pending_cmds.push_back(mk_cmd(CMD_OFFER, 32'h2000_0000 + 32'(k), 32'hFFFF_FFFF,
                                    16'(k), 8'h01 << (k % 8)));
    pending_cmds.push_back(mk_cmd(CMD_FLUSH, '0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(CMD_CLEAR, '0, '0, '0, '0));
    drain();

    // random phases across register settings, one long stretch without gaps
    for (int ph = 0; ph < 5; ph++) begin
      for (int k = 0; k < 8; k++) pool[k] = {8'($urandom_range(255)), 24'h0} | 32'(k << 8);
      write_reg(REG_NUM_IFACES, (ph == 4) ? 32'd7 : 32'(ph));
      write_reg(REG_IFACE_A, (ph == 4) ? 32'hFFFF_FFFF : pool[0] | 32'h1);
      write_reg(REG_IFACE_B, (ph == 4) ? 32'h0 : pool[1] | 32'h3);
      write_reg(REG_IFACE_C, $urandom);
      write_reg(REG_IFACE_D, pool[3] | 32'h7);
      quiet_mode = (ph == 2);
      random_phase(80, pool);
      if (ph == 1) begin
        // sender holds off until everything is back, then resumes
        while (pending_cmds.size() > 40) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_words.size() != 0 || busy || start) @(posedge clk);
        repeat (3) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
      pending_cmds.push_back(mk_cmd(CMD_CLEAR, '0, '0, '0, '0));
      drain();
    end

    $display("covered %0d commands and %0d result words over 6 register settings",
             n_cmds, n_words);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
